@@ design/rpn_pkg.sv @@
// ============================================================================
// rpn_pkg: shared types and codes for the RPN stack calculator
// Field widths, operation and status codes, microcode word layout and
// the step labels of the control program.
// ============================================================================
package rpn_pkg;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int ANSWER_W = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    // operation codes
    localparam op_t OP_PUSH = 3'd0;
    localparam op_t OP_POP  = 3'd1;
    localparam op_t OP_ADD  = 3'd2;
    localparam op_t OP_SUB  = 3'd3;
    localparam op_t OP_MUL  = 3'd4;
    localparam op_t OP_DIV  = 3'd5;

    // status codes
    localparam status_t ST_OK    = 3'd0;
    localparam status_t ST_EMPTY = 3'd1;
    localparam status_t ST_FEW   = 3'd2;
    localparam status_t ST_DZERO = 3'd3;
    localparam status_t ST_FULL  = 3'd4;

    // microcode program counter
    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    // step labels
    localparam upc_t U_IDLE      = 5'd0;
    localparam upc_t U_PUSH_CHK  = 5'd1;
    localparam upc_t U_PUSH_WR   = 5'd2;
    localparam upc_t U_POP_CHK   = 5'd3;
    localparam upc_t U_POP_RD    = 5'd4;
    localparam upc_t U_POP_LD    = 5'd5;
    localparam upc_t U_AR_CHK    = 5'd6;
    localparam upc_t U_AR_RD2    = 5'd7;
    localparam upc_t U_AR_RD1    = 5'd8;
    localparam upc_t U_AR_LDA    = 5'd9;
    localparam upc_t U_AR_EXEC   = 5'd10;
    localparam upc_t U_AR_WAIT   = 5'd11;
    localparam upc_t U_AR_COMMIT = 5'd12;
    localparam upc_t U_ERR_FULL  = 5'd13;
    localparam upc_t U_ERR_EMPTY = 5'd14;
    localparam upc_t U_ERR_FEW   = 5'd15;
    localparam upc_t U_ERR_DZERO = 5'd16;
    localparam upc_t U_EMIT      = 5'd17;

    // jump conditions
    localparam int COND_W = 4;
    typedef logic [COND_W-1:0] cond_t;
    localparam cond_t C_NEXT     = 4'd0;
    localparam cond_t C_ALWAYS   = 4'd1;
    localparam cond_t C_DISPATCH = 4'd2;
    localparam cond_t C_FULL     = 4'd3;
    localparam cond_t C_EMPTY    = 4'd4;
    localparam cond_t C_LT2      = 4'd5;
    localparam cond_t C_DZERO    = 4'd6;
    localparam cond_t C_FAST     = 4'd7;
    localparam cond_t C_BUSY     = 4'd8;
    localparam cond_t C_OUTWAIT  = 4'd9;

    // stack read address select
    typedef logic [1:0] rd_sel_t;
    localparam rd_sel_t RD_NONE = 2'd0;
    localparam rd_sel_t RD_TOP  = 2'd1;
    localparam rd_sel_t RD_NEXT = 2'd2;

    // stack write select
    typedef logic [1:0] wr_sel_t;
    localparam wr_sel_t WR_NONE = 2'd0;
    localparam wr_sel_t WR_PUSH = 2'd1;
    localparam wr_sel_t WR_RES  = 2'd2;

    // stack pointer action
    typedef logic [1:0] sp_op_t;
    localparam sp_op_t SP_HOLD = 2'd0;
    localparam sp_op_t SP_INC  = 2'd1;
    localparam sp_op_t SP_DEC  = 2'd2;

    // result register source
    typedef logic [1:0] res_sel_t;
    localparam res_sel_t RES_HOLD  = 2'd0;
    localparam res_sel_t RES_RDATA = 2'd1;
    localparam res_sel_t RES_ALU   = 2'd2;
    localparam res_sel_t RES_UNIT  = 2'd3;

    typedef struct packed {
        cond_t    cond;
        upc_t     target;
        rd_sel_t  rd;
        wr_sel_t  wr;
        sp_op_t   sp;
        logic     ld_a;
        logic     ld_b;
        res_sel_t res;
        logic     set_has;
        logic     start;
        logic     stat_ld;
        status_t  stat;
        logic     emit;
    } ucode_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic req_valid;
        op_t  op;
        logic full;
        logic empty;
        logic lt2;
        logic dzero;
        logic fast;
        logic busy;
        logic out_busy;
    } flags_t;

endpackage

@@ design/rpn_req_if.sv @@
// ============================================================================
// rpn_req_if: request channel of the RPN stack calculator
// Valid/ready handshake carrying one operation and its push operand.
// ============================================================================
interface rpn_req_if;
    import rpn_pkg::*;

    logic                      valid;
    logic                      ready;
    op_t                       op;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

@@ design/rpn_rsp_if.sv @@
// ============================================================================
// rpn_rsp_if: response channel of the RPN stack calculator
// Valid/ready handshake carrying the answer, status and stack depth.
// ============================================================================
interface rpn_rsp_if;
    import rpn_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [ANSWER_W-1:0] answer;
    logic                       has_answer;
    status_t                    status;
    logic [COUNT_W-1:0]         stack_count;

    modport source (output valid, output answer, output has_answer, output status,
                    output stack_count, input ready);
    modport sink   (input valid, input answer, input has_answer, input status,
                    input stack_count, output ready);
endinterface

@@ design/rpn_ram.sv @@
// ============================================================================
// rpn_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ design/rpn_muldiv.sv @@
// ============================================================================
// rpn_muldiv: iterative multiply / divide unit
// Shift-add multiply and restoring signed divide, one bit per cycle.
// Divide truncates toward zero; multiply keeps the low WIDTH bits.
// ============================================================================
module rpn_muldiv #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             is_div,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic             busy,
    output logic [WIDTH-1:0] result
);
    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             div_reg;
    logic             neg_reg;
    logic [WIDTH-1:0] x_reg;
    logic [WIDTH-1:0] y_reg;
    logic [WIDTH-1:0] acc_reg;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   diff;
    logic [WIDTH-1:0] a_mag;
    logic [WIDTH-1:0] b_mag;

    assign busy   = (cnt_reg != '0);
    assign a_mag  = a[WIDTH-1] ? (~a + WIDTH'(1)) : a;
    assign b_mag  = b[WIDTH-1] ? (~b + WIDTH'(1)) : b;
    assign rem_sh = {acc_reg, x_reg[WIDTH-1]};
    assign diff   = rem_sh - {1'b0, y_reg};

    always_comb
    begin
        if (div_reg)
        begin
            result = neg_reg ? (~x_reg + WIDTH'(1)) : x_reg;
        end
        else
        begin
            result = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(WIDTH);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= is_div;
            neg_reg <= a[WIDTH-1] ^ b[WIDTH-1];
            acc_reg <= '0;
            x_reg   <= is_div ? a_mag : a;
            y_reg   <= is_div ? b_mag : b;
        end
        else if (busy)
        begin
            if (div_reg)
            begin
                // restoring step: subtract the divisor when it fits
                if (!diff[WIDTH])
                begin
                    acc_reg <= diff[WIDTH-1:0];
                end
                else
                begin
                    acc_reg <= rem_sh[WIDTH-1:0];
                end
                x_reg <= {x_reg[WIDTH-2:0], ~diff[WIDTH]};
            end
            else
            begin
                if (y_reg[0])
                begin
                    acc_reg <= acc_reg + x_reg;
                end
                x_reg <= {x_reg[WIDTH-2:0], 1'b0};
                y_reg <= {1'b0, y_reg[WIDTH-1:1]};
            end
        end
    end
endmodule

@@ design/rpn_useq.sv @@
// ============================================================================
// rpn_useq: microcode sequencer of the RPN stack calculator
// Control program in a read-only table, a step counter and the
// next-step logic with operation dispatch and conditional jumps.
// ============================================================================
module rpn_useq (
    input  logic            clk,
    input  logic            rst_n,
    input  rpn_pkg::flags_t flags,
    output rpn_pkg::ucode_t ctrl,
    output logic            idle
);
    import rpn_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    upc_t upc_inc;
    logic jump;

    function automatic ucode_t rom(input upc_t addr);
        ucode_t w;
        w = '0;
        case (addr)
            U_IDLE:
            begin
                w.cond = C_DISPATCH;
            end
            U_PUSH_CHK:
            begin
                w.cond   = C_FULL;
                w.target = U_ERR_FULL;
            end
            U_PUSH_WR:
            begin
                w.cond   = C_ALWAYS;
                w.target = U_EMIT;
                w.wr     = WR_PUSH;
                w.sp     = SP_INC;
            end
            U_POP_CHK:
            begin
                w.cond   = C_EMPTY;
                w.target = U_ERR_EMPTY;
            end
            U_POP_RD:
            begin
                w.rd = RD_TOP;
                w.sp = SP_DEC;
            end
            U_POP_LD:
            begin
                w.cond    = C_ALWAYS;
                w.target  = U_EMIT;
                w.res     = RES_RDATA;
                w.set_has = 1'b1;
            end
            U_AR_CHK:
            begin
                w.cond   = C_LT2;
                w.target = U_ERR_FEW;
            end
            U_AR_RD2:
            begin
                w.rd = RD_TOP;
            end
            U_AR_RD1:
            begin
                w.ld_b = 1'b1;
                w.rd   = RD_NEXT;
            end
            U_AR_LDA:
            begin
                w.ld_a   = 1'b1;
                w.cond   = C_DZERO;
                w.target = U_ERR_DZERO;
            end
            U_AR_EXEC:
            begin
                w.res    = RES_ALU;
                w.start  = 1'b1;
                w.cond   = C_FAST;
                w.target = U_AR_COMMIT;
            end
            U_AR_WAIT:
            begin
                w.res    = RES_UNIT;
                w.cond   = C_BUSY;
                w.target = U_AR_WAIT;
            end
            U_AR_COMMIT:
            begin
                w.wr      = WR_RES;
                w.sp      = SP_DEC;
                w.set_has = 1'b1;
                w.cond    = C_ALWAYS;
                w.target  = U_EMIT;
            end
            U_ERR_FULL:
            begin
                w.stat_ld = 1'b1;
                w.stat    = ST_FULL;
                w.cond    = C_ALWAYS;
                w.target  = U_EMIT;
            end
            U_ERR_EMPTY:
            begin
                w.stat_ld = 1'b1;
                w.stat    = ST_EMPTY;
                w.cond    = C_ALWAYS;
                w.target  = U_EMIT;
            end
            U_ERR_FEW:
            begin
                w.stat_ld = 1'b1;
                w.stat    = ST_FEW;
                w.cond    = C_ALWAYS;
                w.target  = U_EMIT;
            end
            U_ERR_DZERO:
            begin
                w.stat_ld = 1'b1;
                w.stat    = ST_DZERO;
                w.cond    = C_ALWAYS;
                w.target  = U_EMIT;
            end
            U_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = C_OUTWAIT;
                w.target = U_IDLE;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic upc_t dispatch(input op_t op);
        upc_t entry;
        case (op)
            OP_PUSH: entry = U_PUSH_CHK;
            OP_POP:  entry = U_POP_CHK;
            OP_ADD,
            OP_SUB,
            OP_MUL,
            OP_DIV:  entry = U_AR_CHK;
            default: entry = U_EMIT;
        endcase
        return entry;
    endfunction

    assign ctrl    = rom(upc_reg);
    assign idle    = (upc_reg == U_IDLE);
    assign upc_inc = upc_reg + UPC_W'(1);

    always_comb
    begin
        case (ctrl.cond)
            C_FULL:  jump = flags.full;
            C_EMPTY: jump = flags.empty;
            C_LT2:   jump = flags.lt2;
            C_DZERO: jump = flags.dzero;
            C_FAST:  jump = flags.fast;
            C_BUSY:  jump = flags.busy;
            C_ALWAYS: jump = 1'b1;
            default: jump = 1'b0;
        endcase
    end

    always_comb
    begin
        case (ctrl.cond)
            C_DISPATCH: upc_next = flags.req_valid ? dispatch(flags.op) : upc_reg;
            // hold until the output register can take the transaction
            C_OUTWAIT:  upc_next = flags.out_busy ? upc_reg : ctrl.target;
            default:    upc_next = jump ? ctrl.target : upc_inc;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end
endmodule

@@ design/rpn_stack_calculator_core.sv @@
// A request is accepted only while the sequencer is idle, so a new request waits
// until the previous response has been loaded into the response register.
// The microcode steps run one per cycle unless a step waits for a request, the busy
// shared multiply/divide unit or a stalled response; the unit retires one bit a cycle.
// A waiting response does not block the next request.
// Reset (rst_n, async low) empties the stack and clears the response valid.
// ============================================================================
// rpn_stack_calculator_core: integer RPN calculator on a bounded stack
// Microcoded datapath: operand stack in RAM, operand and result
// registers, iterative multiply/divide unit and a response register.
// ============================================================================
module rpn_stack_calculator_core #(
    parameter int STACK_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    rpn_req_if.sink    req,
    rpn_rsp_if.source  rsp
);
    import rpn_pkg::*;

    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    ucode_t ctrl;
    flags_t flags;
    logic   idle;

    logic [SP_W-1:0]       sp_reg;
    logic [SP_W-1:0]       sp_m1;
    logic [SP_W-1:0]       sp_m2;
    op_t                   op_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] b_reg;
    logic [DATA_WIDTH-1:0] res_reg;
    logic [DATA_WIDTH-1:0] res_next;
    logic                  has_reg;
    status_t               status_reg;

    logic                  req_fire;
    logic                  out_busy;
    logic                  emit_go;
    logic                  fast;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  unit_busy;
    logic [DATA_WIDTH-1:0] unit_result;
    logic [DATA_WIDTH-1:0] alu_result;

    logic                        out_valid_reg;
    logic signed [ANSWER_W-1:0]  out_answer_reg;
    logic                        out_has_reg;
    status_t                     out_status_reg;
    logic [COUNT_W-1:0]          out_count_reg;

    assign req.ready = idle;
    assign req_fire  = req.valid & idle;
    assign out_busy  = out_valid_reg & ~rsp.ready;
    assign emit_go   = ctrl.emit & ~out_busy;
    assign fast      = (op_reg == OP_ADD) || (op_reg == OP_SUB);

    assign sp_m1 = sp_reg - SP_W'(1);
    assign sp_m2 = sp_reg - SP_W'(2);

    assign flags.req_valid = req.valid;
    assign flags.op        = req.op;
    assign flags.full      = (sp_reg == SP_W'(STACK_DEPTH));
    assign flags.empty     = (sp_reg == '0);
    assign flags.lt2       = (sp_reg < SP_W'(2));
    assign flags.dzero     = (op_reg == OP_DIV) && (b_reg == '0);
    assign flags.fast      = fast;
    assign flags.busy      = unit_busy;
    assign flags.out_busy  = out_busy;

    rpn_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .idle  (idle)
    );

    // stack memory: push writes at the pointer, a result overwrites the first operand
    assign ram_we    = (ctrl.wr != WR_NONE);
    assign ram_waddr = (ctrl.wr == WR_PUSH) ? sp_reg[ADDR_W-1:0] : sp_m2[ADDR_W-1:0];
    assign ram_wdata = (ctrl.wr == WR_PUSH) ? val_reg : res_reg;
    assign ram_re    = (ctrl.rd != RD_NONE);
    assign ram_raddr = (ctrl.rd == RD_TOP) ? sp_m1[ADDR_W-1:0] : sp_m2[ADDR_W-1:0];

    rpn_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rpn_muldiv #(
        .WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctrl.start & ~fast),
        .is_div (op_reg == OP_DIV),
        .a      (a_reg),
        .b      (b_reg),
        .busy   (unit_busy),
        .result (unit_result)
    );

    assign alu_result = (op_reg == OP_SUB) ? (a_reg - b_reg) : (a_reg + b_reg);

    always_comb
    begin
        case (ctrl.res)
            RES_RDATA: res_next = ram_rdata;
            RES_ALU:   res_next = alu_result;
            RES_UNIT:  res_next = unit_result;
            default:   res_next = res_reg;
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg  <= req.op;
            val_reg <= DATA_WIDTH'(req.value);
        end
        if (ctrl.ld_a)
        begin
            a_reg <= ram_rdata;
        end
        if (ctrl.ld_b)
        begin
            b_reg <= ram_rdata;
        end
        res_reg <= res_next;
        if (emit_go)
        begin
            out_answer_reg <= has_reg ? ANSWER_W'($signed(res_reg)) : '0;
            out_has_reg    <= has_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_W'(sp_reg);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            has_reg       <= 1'b0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (ctrl.sp)
                SP_INC:  sp_reg <= sp_reg + SP_W'(1);
                SP_DEC:  sp_reg <= sp_m1;
                default: sp_reg <= sp_reg;
            endcase

            if (emit_go)
            begin
                has_reg    <= 1'b0;
                status_reg <= ST_OK;
            end
            else
            begin
                if (ctrl.set_has)
                begin
                    has_reg <= 1'b1;
                end
                if (ctrl.stat_ld)
                begin
                    status_reg <= ctrl.stat;
                end
            end

            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.answer      = out_answer_reg;
    assign rsp.has_answer  = out_has_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.stack_count = out_count_reg;
endmodule

@@ design/rpn_checker.sv @@
// ============================================================================
// rpn_checker: port-level checks for the RPN stack calculator
// Watches the response channel and checks stall behavior and the
// consistency of answer, status and stack depth.
// ============================================================================
module rpn_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [rpn_pkg::ANSWER_W-1:0]    answer,
    input logic                            has_answer,
    input rpn_pkg::status_t                status,
    input logic [rpn_pkg::COUNT_W-1:0]     stack_count
);
    import rpn_pkg::*;

    // a stalled response transaction holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable({answer, has_answer, status, stack_count}))
        else $error("response changed while stalled");

    a_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !has_answer |-> answer == '0)
        else $error("answer not zero without a result");

    a_answer_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && has_answer |-> status == ST_OK)
        else $error("result reported with an error status");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_EMPTY) |-> stack_count == '0)
        else $error("pop on empty reported with a nonzero depth");

    a_few_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FEW) |-> stack_count < COUNT_W'(2))
        else $error("too few operands reported with two or more entries");
endmodule

bind rpn_stack_calculator_core rpn_checker u_rpn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .answer      (rsp.answer),
    .has_answer  (rsp.has_answer),
    .status      (rsp.status),
    .stack_count (rsp.stack_count)
);
